// ===== rtl/hcbp_pkg.sv =====
// hcbp_pkg: shared types and constants for the Huffman code bit packer.
// No dependencies; every other file of the block uses it.

package hcbp_pkg;

   localparam int SYMBOL_COUNT = 256;
   localparam int MAX_CODE_LEN = 32;

   localparam int SYM_W   = 8;
   localparam int CODE_W  = 32;
   localparam int LEN_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   // accumulator holds up to seven leftover bits plus one full code
   localparam int ACC_W   = LEN_LIMIT + BYTE_W - 1;
   localparam int SHIFT_W = $clog2(ACC_W + 1);

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_ENCODE = 2'd1,
      CMD_FLUSH  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // lookup stage contents handed from the code table to the packer
   typedef struct packed {
      logic                valid;
      cmd_type             cmd;
      logic                hit;     // symbol inside the table
      logic [CODE_W-1:0]   code;
      logic [LEN_W-1:0]    length;
   } lookup_type;

endpackage

// ===== rtl/hcbp_if.sv =====
// hcbp_if: valid/ready channel interfaces for request and response items.
// Depends on hcbp_pkg for field widths.

interface hcbp_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic [hcbp_pkg::SYM_W-1:0]    symbol;
   logic [hcbp_pkg::CODE_W-1:0]   code_bits;
   logic [hcbp_pkg::LEN_W-1:0]    code_length;

   modport source (output valid, command, symbol, code_bits, code_length, input ready);
   modport sink   (input valid, command, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hcbp_pkg::BYTE_W-1:0]   packed_byte;
   logic                          last_of_run;

   modport source (output valid, packed_byte, last_of_run, input ready);
   modport sink   (input valid, packed_byte, last_of_run, output ready);
endinterface

// ===== rtl/huffman_code_bit_packer.sv =====
// huffman_code_bit_packer: top level of the Huffman encoder back end.
// Depends on hcbp_pkg, hcbp_if, hcbp_code_table and hcbp_packer.
//
// Usage
//  req_ch carries commands: write (store a code word and length for a symbol
//  in the 256-entry code table), encode (append the symbol's code to the bit
//  accumulator) and flush (emit the last partial byte, zero padded). The
//  unused command code is taken and ignored.
//  rsp_ch gives packed bytes, earliest bit in bit 7; last_of_run marks the
//  final byte caused by one request item.
// Pipeline
//  A request item is accepted into the lookup stage register, which also
//  holds the registered code table read. An encode's bits then pass the
//  accumulator and the output register; a flush byte is written straight
//  into the output register. The packer takes an item, then issues its
//  bytes one per cycle while rsp_ch.ready is high. An encode releases
//  0..4 bytes; a flush or any item releasing no byte flows back to back.
// Reset
//  Clears the accumulator, the bit count and all valid flags. The code table
//  is not cleared: entries must be written before they are encoded.
// Stall
//  While rsp_ch.ready is low the output register holds its byte; the packer
//  and lookup stage fill and then req_ch.ready drops.

module huffman_code_bit_packer (
   input  logic        clock,
   input  logic        reset,
   hcbp_req_if.sink    req_ch,
   hcbp_rsp_if.source  rsp_ch
);

   hcbp_pkg::lookup_type lookup;
   logic                 take;

   // code table memory plus registered lookup stage
   hcbp_code_table u_table (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .take   (take),
      .lookup (lookup)
   );

   // accumulator and output register
   hcbp_packer u_packer (
      .clock  (clock),
      .reset  (reset),
      .lookup (lookup),
      .take   (take),
      .rsp_ch (rsp_ch)
   );

endmodule

// ===== rtl/hcbp_code_table.sv =====
// hcbp_code_table: code word/length memory and the lookup stage register.
// Depends on hcbp_pkg and hcbp_if.

module hcbp_code_table (
   input  logic                 clock,
   input  logic                 reset,
   hcbp_req_if.sink             req_ch,
   input  logic                 take,
   output hcbp_pkg::lookup_type lookup
);

   localparam int ENTRY_W = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

   logic [ENTRY_W-1:0]         mem [hcbp_pkg::SYMBOL_COUNT];
   logic [ENTRY_W-1:0]         rd_data_ff;
   logic                       valid_ff, valid_in;
   hcbp_pkg::cmd_type          cmd_ff;
   logic                       hit_ff;

   logic                       accept;
   logic                       in_range;
   logic [hcbp_pkg::IDX_W-1:0] idx;
   logic [hcbp_pkg::LEN_W-1:0] len_sat;
   logic [hcbp_pkg::CODE_W:0]  len_mask;
   hcbp_pkg::cmd_type          cmd;

   assign cmd      = hcbp_pkg::cmd_type'(req_ch.command);
   assign req_ch.ready = !valid_ff || take;
   assign accept   = req_ch.valid && req_ch.ready;
   assign in_range = {1'b0, req_ch.symbol} < (hcbp_pkg::SYM_W+1)'(hcbp_pkg::SYMBOL_COUNT);
   assign idx      = req_ch.symbol[hcbp_pkg::IDX_W-1:0];

   // saturate length, drop bits above it
   assign len_sat  = (req_ch.code_length > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT))
                   ? hcbp_pkg::LEN_W'(hcbp_pkg::LEN_LIMIT) : req_ch.code_length;
   assign len_mask = ((hcbp_pkg::CODE_W+1)'(1) << len_sat) - (hcbp_pkg::CODE_W+1)'(1);

   always_ff @(posedge clock) begin
      if (accept) begin
         if (cmd == hcbp_pkg::CMD_WRITE && in_range) begin
            mem[idx] <= {req_ch.code_bits & len_mask[hcbp_pkg::CODE_W-1:0], len_sat};
         end
         rd_data_ff <= mem[idx];
         cmd_ff     <= cmd;
         hit_ff     <= in_range;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign lookup.valid  = valid_ff;
   assign lookup.cmd    = cmd_ff;
   assign lookup.hit    = hit_ff;
   assign lookup.code   = rd_data_ff[ENTRY_W-1:hcbp_pkg::LEN_W];
   assign lookup.length = rd_data_ff[hcbp_pkg::LEN_W-1:0];

endmodule

// ===== rtl/hcbp_packer.sv =====
// hcbp_packer: bit accumulator, byte extraction and response output register.
// Depends on hcbp_pkg and hcbp_if.

module hcbp_packer (
   input  logic                 clock,
   input  logic                 reset,
   input  hcbp_pkg::lookup_type lookup,
   output logic                 take,
   hcbp_rsp_if.source           rsp_ch
);

   logic [hcbp_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [hcbp_pkg::SHIFT_W-1:0] cnt_ff, cnt_in;
   logic                         out_valid_ff, out_valid_in;
   logic [hcbp_pkg::BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic                         out_last_ff, out_last_in;

   logic                         out_free;
   logic                         has_byte;
   logic                         emit;
   logic                         flush_byte;
   logic [hcbp_pkg::LEN_W-1:0]   n;
   logic [hcbp_pkg::SHIFT_W-1:0] rem;
   logic [hcbp_pkg::ACC_W-1:0]   acc_shr;
   logic [3:0]                   pad;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign has_byte = cnt_ff >= hcbp_pkg::SHIFT_W'(hcbp_pkg::BYTE_W);
   assign emit     = out_free && has_byte;
   // next item enters only once the previous one has drained its full bytes
   assign take     = lookup.valid && !has_byte
                  && (lookup.cmd != hcbp_pkg::CMD_FLUSH || cnt_ff == '0 || out_free);
   assign flush_byte = take && lookup.cmd == hcbp_pkg::CMD_FLUSH && cnt_ff != '0;

   assign n = (lookup.cmd == hcbp_pkg::CMD_ENCODE && lookup.hit) ? lookup.length : '0;
   assign rem     = cnt_ff - hcbp_pkg::SHIFT_W'(hcbp_pkg::BYTE_W);
   assign acc_shr = acc_ff >> rem;
   assign pad     = 4'd8 - {1'b0, cnt_ff[2:0]};

   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         cnt_in       = rem;
         out_valid_in = 1'b1;
         out_byte_in  = acc_shr[hcbp_pkg::BYTE_W-1:0];
         out_last_in  = rem < hcbp_pkg::SHIFT_W'(hcbp_pkg::BYTE_W);
      end else if (take) begin
         case (lookup.cmd)
            hcbp_pkg::CMD_ENCODE: begin
               acc_in = (acc_ff << n)
                      | hcbp_pkg::ACC_W'(lookup.code & ~(hcbp_pkg::CODE_W'(0)));
               cnt_in = cnt_ff + hcbp_pkg::SHIFT_W'(n);
            end
            hcbp_pkg::CMD_FLUSH: begin
               acc_in = '0;
               cnt_in = '0;
               if (flush_byte) begin
                  out_valid_in = 1'b1;
                  out_byte_in  = acc_ff[hcbp_pkg::BYTE_W-1:0] << pad;
                  out_last_in  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.packed_byte = out_byte_ff;
   assign rsp_ch.last_of_run = out_last_ff;

endmodule

// ===== rtl/hcbp_checker.sv =====
// hcbp_checker: port-level assertions for huffman_code_bit_packer, with bind.
// Depends on hcbp_pkg for field widths.

module hcbp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [hcbp_pkg::BYTE_W-1:0] rsp_byte,
   input logic                        rsp_last
);

   // stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
      else $error("response item changed while stalled");

   // no byte reaches the output while the pipeline refills after reset
   a_rsp_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("response valid too soon after reset");

   // pipeline is empty after reset, so a request is taken at once
   a_req_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request not ready after reset");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_byte  (rsp_ch.packed_byte),
   .rsp_last  (rsp_ch.last_of_run)
);
